[rtl/gcdh_pkg.sv]
// gcdh_pkg: shared widths, constants, types and saturation helpers for the
// gru cell / dense head block; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package gcdh_pkg;

  localparam int Q_W      = 16;
  localparam int ACC_W    = 40;
  localparam int PRE_W    = ACC_W - 12;
  localparam int STORE_AW = 11;

  localparam logic signed [Q_W-1:0] ONE_Q12  = 16'sd4096;
  localparam logic signed [Q_W-1:0] TANH_SAT = 16'sd4076;

  // divider for the rational tanh
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 34;
  localparam int DIV_QW = 14;
  localparam int DIV_CW = 4;

  typedef struct packed {
    logic clear;
    logic load;
    logic shift;
  } cell_ctl_t;

  typedef struct packed {
    logic                    start;
    logic                    sigm;
    logic signed [PRE_W-1:0] x;
  } act_req_t;

  function automatic logic signed [15:0] sat16(input logic signed [47:0] v);
    logic signed [15:0] r;
    if (v > 48'sd32767) r = 16'sh7fff;
    else if (v < -48'sd32768) r = 16'sh8000;
    else r = v[15:0];
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v > 48'sd2147483647) r = 32'sh7fffffff;
    else if (v < -48'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage
`default_nettype wire

[rtl/gcdh_cell.sv]
// gcdh_cell: one Q4.12 storage cell of a chain; takes its neighbor's value on
// shift, a parallel value on load, zero on clear; uses gcdh_pkg
`timescale 1ns / 1ps
`default_nettype none
module gcdh_cell (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire gcdh_pkg::cell_ctl_t ctl_i,
  input  wire logic signed [15:0] nb_i,
  input  wire logic signed [15:0] ld_i,
  output logic signed [15:0]      q_o
);
  import gcdh_pkg::*;

  logic signed [15:0] val_q, val_d;

  always_comb begin
    val_d = val_q;
    if (ctl_i.clear) val_d = '0;
    else if (ctl_i.load) val_d = ld_i;
    else if (ctl_i.shift) val_d = nb_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) val_q <= '0;
    else val_q <= val_d;
  end

  assign q_o = val_q;

endmodule
`default_nettype wire

[rtl/gcdh_div.sv]
// gcdh_div: restoring divider, one quotient bit per cycle
// uses gcdh_pkg widths
`timescale 1ns / 1ps
`default_nettype none
module gcdh_div (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   start_i,
  input  wire [gcdh_pkg::DIV_NW-1:0] num_i,
  input  wire [gcdh_pkg::DIV_DW-1:0] den_i,
  output logic                  done_o,
  output logic [gcdh_pkg::DIV_QW-1:0] quo_o
);
  import gcdh_pkg::*;

  logic [DIV_CW-1:0] cnt_q;
  logic              done_q;
  logic [DIV_NW-1:0] rem_q, dsh_q;
  logic [DIV_QW-1:0] quo_q;
  logic              ge;

  assign ge = (rem_q >= dsh_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= DIV_CW'(DIV_QW);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == DIV_CW'(1)) done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      dsh_q <= DIV_NW'(den_i) << (DIV_QW - 1);
    end else if (cnt_q != '0) begin
      if (ge) rem_q <= rem_q - dsh_q;
      quo_q <= {quo_q[DIV_QW-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

[rtl/gcdh_act.sv]
// gcdh_act: tanh (rational, clamped at +-3) and sigmoid (from tanh of x/2,
// clamped at +-8) in Q4.12; uses gcdh_pkg and gcdh_div
`timescale 1ns / 1ps
`default_nettype none
module gcdh_act (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire gcdh_pkg::act_req_t req_i,
  output logic                 done_o,
  output logic signed [15:0]   y_o
);
  import gcdh_pkg::*;

  typedef enum logic [6:0] {
    A_IDLE = 7'b0000001,
    A_SQ   = 7'b0000010,
    A_SUM  = 7'b0000100,
    A_MUL  = 7'b0001000,
    A_DIV  = 7'b0010000,
    A_WAIT = 7'b0100000,
    A_FIN  = 7'b1000000
  } act_state_e;

  act_state_e state_q;
  logic       done_q;
  logic       sigm_q, f13_q, neg_q;
  logic signed [15:0] v_q, t_q, y_q;
  logic [30:0] x2_q;
  logic [31:0] sum_q;
  logic [DIV_DW-1:0] den_q;
  logic [14:0] magv_q;
  logic [46:0] mag_q;

  logic signed [PRE_W-1:0] lim;
  logic signed [31:0] sq;
  logic [31:0] c_v;
  logic [33:0] den_b;
  logic div_done;
  logic [DIV_QW-1:0] quo;
  logic signed [16:0] tp;

  assign lim   = req_i.sigm ? PRE_W'(24576) : PRE_W'(12288);
  assign sq    = v_q * v_q;
  assign c_v   = f13_q ? (32'd27 << 26) : (32'd27 << 24);
  assign den_b = {2'b00, c_v} + 34'(x2_q) * 34'd9;
  assign tp    = {t_q[15], t_q} + 17'sd4097;

  gcdh_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == A_DIV),
    .num_i   (DIV_NW'(mag_q) + DIV_NW'(den_q >> 1)),
    .den_i   (den_q),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= A_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        A_IDLE: begin
          if (req_i.start) begin
            if (req_i.sigm && (req_i.x > PRE_W'(32768) || req_i.x < -PRE_W'(32768))) begin
              done_q <= 1'b1;
            end else if (req_i.x > lim || req_i.x < -lim) begin
              state_q <= A_FIN;
            end else begin
              state_q <= A_SQ;
            end
          end
        end
        A_SQ:   state_q <= A_SUM;
        A_SUM:  state_q <= A_MUL;
        A_MUL:  state_q <= A_DIV;
        A_DIV:  state_q <= A_WAIT;
        A_WAIT: if (div_done) state_q <= A_FIN;
        A_FIN: begin
          done_q  <= 1'b1;
          state_q <= A_IDLE;
        end
        default: state_q <= A_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      A_IDLE: begin
        sigm_q <= req_i.sigm;
        f13_q  <= req_i.sigm;
        v_q    <= req_i.x[15:0];
        if (req_i.x > PRE_W'(32768)) y_q <= 16'sd4095;
        else if (req_i.x < -PRE_W'(32768)) y_q <= 16'sd1;
        if (req_i.x > lim) t_q <= TANH_SAT;
        else if (req_i.x < -lim) t_q <= -TANH_SAT;
      end
      A_SQ: begin
        x2_q   <= sq[30:0];
        neg_q  <= v_q[15];
        magv_q <= v_q[15] ? 15'(-v_q) : v_q[14:0];
      end
      A_SUM: begin
        sum_q <= c_v + {1'b0, x2_q};
        den_q <= f13_q ? {den_b[32:0], 1'b0} : den_b;
      end
      A_MUL: mag_q <= 47'(magv_q) * 47'(sum_q);
      A_WAIT: if (div_done) t_q <= neg_q ? -$signed(16'(quo)) : $signed(16'(quo));
      A_FIN: y_q <= sigm_q ? 16'(tp >>> 1) : t_q;
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign y_o    = y_q;

endmodule
`default_nettype wire

[rtl/gru_cell_dense_head_inference.sv]
// gru_cell_dense_head_inference: weight memory, command decoder, sequencer and
// one MAC pipeline; depends on gcdh_pkg, gcdh_cell, gcdh_act
//
// Usage: drive a command with start_i high; it is taken at an edge where
// busy_o is low. command 0 writes weight_value_i at weight_address_i, 1 zeroes
// the hidden state, 2 scales sample_value_i into feature slot feature_index_i.
// Weight writes and clears keep busy_o low. A feature sample first passes the
// scaling state S_SCALE; the sample for the last slot then runs the
// full GRU step, the dense SiLU layer and the output neuron, and the result
// shows on prediction_o / prediction_scaled_o for one cycle with
// result_valid_o high. The receiver cannot stall; each beat is taken as shown.
// Per full step: per hidden unit 6+3*(INPUT_DIM+HIDDEN_UNITS) MAC issues,
// a drain and three activations; per dense neuron HIDDEN_UNITS+1 issues and one
// activation; then DENSE_WIDTH+1 issues for the output. The step time is set by
// the single weight-memory read port feeding the one multiplier and by the
// bit-serial divider in the activation unit. One item is in work at a time.
// Reset clears the hidden chain and restores both registers to 65536; weight
// memory and feature slots hold garbage until written.
// cfg_we_i writes cfg_data_i to register cfg_index_i at the clock edge.
`timescale 1ns / 1ps
`default_nettype none
module gru_cell_dense_head_inference #(
  parameter int INPUT_DIM    = 4,
  parameter int HIDDEN_UNITS = 16,
  parameter int DENSE_WIDTH  = 16
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start_i,
  output logic               busy_o,
  input  wire  [1:0]         command_i,
  input  wire  [10:0]        weight_address_i,
  input  wire  signed [15:0] weight_value_i,
  input  wire  [3:0]         feature_index_i,
  input  wire  signed [31:0] sample_value_i,
  input  wire                cfg_we_i,
  input  wire  [0:0]         cfg_index_i,
  input  wire  [31:0]        cfg_data_i,
  output logic               result_valid_o,
  output logic signed [31:0] prediction_o,
  output logic signed [15:0] prediction_scaled_o
);
  import gcdh_pkg::*;

  localparam int G      = 3 * HIDDEN_UNITS;
  localparam int AT_RK  = INPUT_DIM * G;
  localparam int AT_IB  = AT_RK + HIDDEN_UNITS * G;
  localparam int AT_RB  = AT_IB + G;
  localparam int AT_DK  = AT_RB + G;
  localparam int AT_DB  = AT_DK + HIDDEN_UNITS * DENSE_WIDTH;
  localparam int AT_OK  = AT_DB + DENSE_WIDTH;
  localparam int AT_OB  = AT_OK + DENSE_WIDTH;
  localparam int MAXN_A = (INPUT_DIM > HIDDEN_UNITS) ? INPUT_DIM : HIDDEN_UNITS;
  localparam int MAXN   = (MAXN_A > DENSE_WIDTH) ? MAXN_A : DENSE_WIDTH;
  localparam int CW     = $clog2(MAXN + 1);
  localparam int FIW    = (INPUT_DIM > 1) ? $clog2(INPUT_DIM) : 1;

  typedef enum logic [1:0] {
    CMD_WEIGHT = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_FEAT   = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TAG_Z  = 2'd0,
    TAG_R  = 2'd1,
    TAG_CI = 2'd2,
    TAG_CR = 2'd3
  } tag_e;

  typedef enum logic [1:0] {
    P_BIAS = 2'd0,
    P_INP  = 2'd1,
    P_REC  = 2'd2
  } part_e;

  localparam logic REG_RECIP  = 1'b0;
  localparam logic REG_ORANGE = 1'b1;

  typedef enum logic [22:0] {
    S_IDLE   = 23'h000001,
    S_SCALE  = 23'h000002,
    S_GISSUE = 23'h000004,
    S_GDRAIN = 23'h000008,
    S_ZKICK  = 23'h000010,
    S_ZWAIT  = 23'h000020,
    S_RKICK  = 23'h000040,
    S_RWAIT  = 23'h000080,
    S_RCMUL  = 23'h000100,
    S_CKICK  = 23'h000200,
    S_CWAIT  = 23'h000400,
    S_HMUL   = 23'h000800,
    S_HSUM   = 23'h001000,
    S_DISSUE = 23'h002000,
    S_DDRAIN = 23'h004000,
    S_DKICK  = 23'h008000,
    S_DWAIT  = 23'h010000,
    S_DMUL   = 23'h020000,
    S_DSUM   = 23'h040000,
    S_OISSUE = 23'h080000,
    S_ODRAIN = 23'h100000,
    S_OMUL   = 23'h200000,
    S_OUT    = 23'h400000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] u_q, u_d, o_q, o_d, i_q, i_d;
  logic [1:0]    g_q, g_d;
  part_e         part_q, part_d;

  logic [31:0] recip_q, orange_q;
  logic signed [15:0] fbuf_q [INPUT_DIM];
  logic signed [31:0] sample_q;
  logic [3:0]  fidx_q;

  logic [15:0] mem_q [2**STORE_AW];
  logic [15:0] rd_q;

  logic               v1_q, v2_q;
  tag_e               tag1_q, tag2_q;
  logic signed [15:0] x1_q;
  logic signed [31:0] p2_q;
  logic signed [ACC_W-1:0] acc_q [4];

  logic signed [15:0] z_q, r_q, cand_q, s_q, pu_q, ps_q;
  logic signed [55:0] rc_q;
  logic signed [31:0] t1_q, t2_q;
  logic signed [43:0] dm_q;
  logic signed [48:0] om_q;
  logic signed [31:0] pred_q;
  logic signed [15:0] pss_q;
  logic               valid_q;

  logic       in_acc;
  logic       issue, rot_p, rot_d, cap_pu, acc_clr, shift_h, load_p, shift_dn;
  logic [31:0] iss_a;
  logic signed [15:0] iss_x;
  tag_e       iss_tag;
  act_req_t   act_req;
  logic       act_done;
  logic signed [15:0] act_y;

  logic signed [15:0] pq [HIDDEN_UNITS];
  logic signed [15:0] nq [HIDDEN_UNITS];
  logic signed [15:0] nnb [HIDDEN_UNITS];
  logic signed [15:0] dq [DENSE_WIDTH];
  cell_ctl_t pctl, nctl, dctl;

  // rounded pre-activations and datapath values
  logic signed [ACC_W-1:0] zr_s, rr_s;
  logic signed [PRE_W-1:0] pre_z, pre_r, cpre;
  logic signed [55:0] rcr;
  logic signed [43:0] cs;
  logic signed [32:0] hs;
  logic signed [15:0] h_val, dense_val, ps_v;
  logic signed [43:0] dmr;
  logic signed [48:0] omr;
  logic signed [64:0] prod, prr;
  logic signed [32:0] spr;
  logic signed [15:0] scaled;

  assign in_acc = start_i && !busy_o;
  assign busy_o = (state_q != S_IDLE);

  assign zr_s  = acc_q[TAG_Z] + ACC_W'(2048);
  assign rr_s  = acc_q[TAG_R] + ACC_W'(2048);
  assign pre_z = zr_s[ACC_W-1:12];
  assign pre_r = rr_s[ACC_W-1:12];
  assign rcr   = rc_q + 56'sd2048;
  assign cs    = {{4{acc_q[TAG_CI][ACC_W-1]}}, acc_q[TAG_CI]} + rcr[55:12] + 44'sd2048;
  assign cpre  = cs[39:12];
  assign hs    = {t1_q[31], t1_q} + {t2_q[31], t2_q} + 33'sd2048;
  assign h_val = sat16({{27{hs[32]}}, hs[32:12]});
  assign dmr   = dm_q + 44'sd2048;
  assign dense_val = sat16({{16{dmr[43]}}, dmr[43:12]});
  assign ps_v  = sat16({{20{pre_z[PRE_W-1]}}, pre_z});
  assign omr   = om_q + 49'sd2048;

  assign prod   = sample_q * $signed({1'b0, recip_q});
  assign prr    = prod + 65'sd524288;
  assign spr    = {sample_q[31], sample_q} + 33'sd8;
  assign scaled = (recip_q == 32'd0) ? sat16({{19{spr[32]}}, spr[32:4]})
                                     : sat16({{3{prr[64]}}, prr[64:20]});

  always_comb begin
    state_d  = state_q;
    u_d      = u_q;
    o_d      = o_q;
    i_d      = i_q;
    g_d      = g_q;
    part_d   = part_q;
    issue    = 1'b0;
    iss_a    = '0;
    iss_x    = ONE_Q12;
    iss_tag  = TAG_Z;
    rot_p    = 1'b0;
    rot_d    = 1'b0;
    cap_pu   = 1'b0;
    acc_clr  = 1'b0;
    shift_h  = 1'b0;
    load_p   = 1'b0;
    shift_dn = 1'b0;
    act_req  = '0;
    case (state_q)
      S_IDLE: begin
        if (in_acc && command_i == CMD_FEAT && {1'b0, feature_index_i} < 5'(INPUT_DIM))
          state_d = S_SCALE;
      end
      S_SCALE: begin
        if (fidx_q == 4'(INPUT_DIM - 1)) begin
          state_d = S_GISSUE;
          u_d = '0; i_d = '0; g_d = '0; part_d = P_BIAS; acc_clr = 1'b1;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_GISSUE: begin
        issue = 1'b1;
        case (g_q)
          2'd0:    iss_tag = TAG_Z;
          2'd1:    iss_tag = TAG_R;
          default: iss_tag = (part_q == P_REC || (part_q == P_BIAS && i_q != '0))
                             ? TAG_CR : TAG_CI;
        endcase
        g_d = (g_q == 2'd2) ? 2'd0 : g_q + 2'd1;
        case (part_q)
          P_BIAS: begin
            iss_a = ((i_q == '0) ? 32'(AT_IB) : 32'(AT_RB))
                    + 32'(g_q) * 32'(HIDDEN_UNITS) + 32'(u_q);
            if (g_q == 2'd2) begin
              if (i_q != '0) begin
                part_d = P_INP; i_d = '0;
              end else begin
                i_d = i_q + 1'b1;
              end
            end
          end
          P_INP: begin
            iss_a = 32'(i_q) * 32'(G) + 32'(g_q) * 32'(HIDDEN_UNITS) + 32'(u_q);
            iss_x = fbuf_q[i_q[FIW-1:0]];
            if (g_q == 2'd2) begin
              if (i_q == CW'(INPUT_DIM - 1)) begin
                part_d = P_REC; i_d = '0;
              end else begin
                i_d = i_q + 1'b1;
              end
            end
          end
          default: begin
            iss_a = 32'(AT_RK) + 32'(i_q) * 32'(G) + 32'(g_q) * 32'(HIDDEN_UNITS)
                    + 32'(u_q);
            iss_x = pq[0];
            cap_pu = (g_q == 2'd0) && (i_q == u_q);
            if (g_q == 2'd2) begin
              rot_p = 1'b1;
              if (i_q == CW'(HIDDEN_UNITS - 1)) state_d = S_GDRAIN;
              else i_d = i_q + 1'b1;
            end
          end
        endcase
      end
      S_GDRAIN: if (!v1_q && !v2_q) state_d = S_ZKICK;
      S_ZKICK: begin
        act_req = '{start: 1'b1, sigm: 1'b1, x: pre_z};
        state_d = S_ZWAIT;
      end
      S_ZWAIT: if (act_done) state_d = S_RKICK;
      S_RKICK: begin
        act_req = '{start: 1'b1, sigm: 1'b1, x: pre_r};
        state_d = S_RWAIT;
      end
      S_RWAIT: if (act_done) state_d = S_RCMUL;
      S_RCMUL: state_d = S_CKICK;
      S_CKICK: begin
        act_req = '{start: 1'b1, sigm: 1'b0, x: cpre};
        state_d = S_CWAIT;
      end
      S_CWAIT: if (act_done) state_d = S_HMUL;
      S_HMUL:  state_d = S_HSUM;
      S_HSUM: begin
        shift_h = 1'b1;
        acc_clr = 1'b1;
        i_d = '0; g_d = '0; part_d = P_BIAS;
        if (u_q == CW'(HIDDEN_UNITS - 1)) begin
          // new hidden vector becomes the one the dense layer reads
          load_p  = 1'b1;
          o_d     = '0;
          state_d = S_DISSUE;
        end else begin
          u_d     = u_q + 1'b1;
          state_d = S_GISSUE;
        end
      end
      S_DISSUE: begin
        issue = 1'b1;
        if (part_q == P_BIAS) begin
          iss_a  = 32'(AT_DB) + 32'(o_q);
          part_d = P_REC;
          i_d    = '0;
        end else begin
          iss_a = 32'(AT_DK) + 32'(i_q) * 32'(DENSE_WIDTH) + 32'(o_q);
          iss_x = pq[0];
          rot_p = 1'b1;
          if (i_q == CW'(HIDDEN_UNITS - 1)) state_d = S_DDRAIN;
          else i_d = i_q + 1'b1;
        end
      end
      S_DDRAIN: if (!v1_q && !v2_q) state_d = S_DKICK;
      S_DKICK: begin
        act_req = '{start: 1'b1, sigm: 1'b1, x: pre_z};
        state_d = S_DWAIT;
      end
      S_DWAIT: if (act_done) state_d = S_DMUL;
      S_DMUL:  state_d = S_DSUM;
      S_DSUM: begin
        shift_dn = 1'b1;
        acc_clr  = 1'b1;
        i_d = '0; part_d = P_BIAS;
        if (o_q == CW'(DENSE_WIDTH - 1)) begin
          state_d = S_OISSUE;
        end else begin
          o_d     = o_q + 1'b1;
          state_d = S_DISSUE;
        end
      end
      S_OISSUE: begin
        issue = 1'b1;
        if (part_q == P_BIAS) begin
          iss_a  = 32'(AT_OB);
          part_d = P_REC;
          i_d    = '0;
        end else begin
          iss_a = 32'(AT_OK) + 32'(i_q);
          iss_x = dq[0];
          rot_d = 1'b1;
          if (i_q == CW'(DENSE_WIDTH - 1)) state_d = S_ODRAIN;
          else i_d = i_q + 1'b1;
        end
      end
      S_ODRAIN: if (!v1_q && !v2_q) state_d = S_OMUL;
      S_OMUL:   state_d = S_OUT;
      S_OUT:    state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      u_q      <= '0;
      o_q      <= '0;
      i_q      <= '0;
      g_q      <= '0;
      part_q   <= P_BIAS;
      recip_q  <= 32'd65536;
      orange_q <= 32'd65536;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      u_q     <= u_d;
      o_q     <= o_d;
      i_q     <= i_d;
      g_q     <= g_d;
      part_q  <= part_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      valid_q <= (state_q == S_OUT);
      if (cfg_we_i) begin
        if (cfg_index_i == REG_RECIP) recip_q <= cfg_data_i;
        else if (cfg_index_i == REG_ORANGE) orange_q <= cfg_data_i;
      end
    end
  end

  // weight memory: one write port for commands, one registered read for the mac
  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == CMD_WEIGHT) mem_q[weight_address_i] <= weight_value_i;
    rd_q <= mem_q[iss_a[STORE_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && command_i == CMD_FEAT) begin
      sample_q <= sample_value_i;
      fidx_q   <= feature_index_i;
    end
    if (state_q == S_SCALE) fbuf_q[fidx_q[FIW-1:0]] <= scaled;

    x1_q   <= iss_x;
    tag1_q <= iss_tag;
    p2_q   <= x1_q * $signed(rd_q);
    tag2_q <= tag1_q;
    if (acc_clr) begin
      for (int k = 0; k < 4; k++) acc_q[k] <= '0;
    end else if (v2_q) begin
      acc_q[tag2_q] <= acc_q[tag2_q] + {{(ACC_W-32){p2_q[31]}}, p2_q};
    end

    if (cap_pu) pu_q <= pq[0];
    if (act_done) begin
      case (state_q)
        S_ZWAIT: z_q    <= act_y;
        S_RWAIT: r_q    <= act_y;
        S_CWAIT: cand_q <= act_y;
        S_DWAIT: s_q    <= act_y;
        default: ;
      endcase
    end
    if (state_q == S_RCMUL) rc_q <= r_q * acc_q[TAG_CR];
    if (state_q == S_HMUL) begin
      t1_q <= z_q * pu_q;
      t2_q <= (ONE_Q12 - z_q) * cand_q;
    end
    if (state_q == S_DMUL) dm_q <= pre_z * s_q;
    if (state_q == S_OMUL) begin
      ps_q <= ps_v;
      om_q <= ps_v * $signed({1'b0, orange_q});
    end
    if (state_q == S_OUT) begin
      pred_q <= sat32({{11{omr[48]}}, omr[48:12]});
      pss_q  <= ps_q;
    end
  end

  gcdh_act u_act (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (act_req),
    .done_o (act_done),
    .y_o    (act_y)
  );

  // hidden chains: previous state rotates past the mac, new state shifts in
  assign pctl = '{clear: in_acc && command_i == CMD_CLEAR, load: load_p, shift: rot_p};
  assign nctl = '{clear: 1'b0, load: 1'b0, shift: shift_h};
  assign dctl = '{clear: 1'b0, load: 1'b0, shift: shift_dn || rot_d};

  for (genvar k = 0; k < HIDDEN_UNITS; k++) begin : g_hid
    if (k == HIDDEN_UNITS - 1) begin : g_tail
      assign nnb[k] = h_val;
      gcdh_cell u_prev (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (pctl),
        .nb_i (pq[0]), .ld_i (nnb[k]), .q_o (pq[k])
      );
    end else begin : g_mid
      assign nnb[k] = nq[k+1];
      gcdh_cell u_prev (
        .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (pctl),
        .nb_i (pq[k+1]), .ld_i (nnb[k]), .q_o (pq[k])
      );
    end
    gcdh_cell u_new (
      .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (nctl),
      .nb_i (nnb[k]), .ld_i (nnb[k]), .q_o (nq[k])
    );
  end

  for (genvar k = 0; k < DENSE_WIDTH; k++) begin : g_dns
    logic signed [15:0] dnb;
    if (k == DENSE_WIDTH - 1) begin : g_tail
      assign dnb = shift_dn ? dense_val : dq[0];
    end else begin : g_mid
      assign dnb = dq[k+1];
    end
    gcdh_cell u_dense (
      .clk_i (clk_i), .rst_ni (rst_ni), .ctl_i (dctl),
      .nb_i (dnb), .ld_i (dnb), .q_o (dq[k])
    );
  end

  assign result_valid_o      = valid_q;
  assign prediction_o        = pred_q;
  assign prediction_scaled_o = pss_q;

endmodule
`default_nettype wire

[tb/gru_cell_dense_head_inference_tb.sv]
// gru_cell_dense_head_inference_tb: self-checking bench for the gru cell / dense head block;
// predicts each prediction beat in fixed point and compares it field by field.
// depends on the rtl top gru_cell_dense_head_inference only
`timescale 1ns / 1ps
module gru_cell_dense_head_inference_tb;

  localparam int IN_DIM  = 4;
  localparam int HID     = 16;
  localparam int DWID    = 16;
  localparam int GATES   = 3 * HID;
  localparam int A_RKER  = IN_DIM * GATES;
  localparam int A_IBIAS = A_RKER + HID * GATES;
  localparam int A_RBIAS = A_IBIAS + GATES;
  localparam int A_DKER  = A_RBIAS + GATES;
  localparam int A_DBIAS = A_DKER + HID * DWID;
  localparam int A_OKER  = A_DBIAS + DWID;
  localparam int A_OBIAS = A_OKER + DWID;
  localparam int N_WORDS = A_OBIAS + 1;
  localparam longint Q12_ONE = 4096;

  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_CLEAR  = 2'd1;
  localparam logic [1:0] CMD_SAMPLE = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic REG_IN_RECIP  = 1'b0;
  localparam logic REG_OUT_RANGE = 1'b1;

  typedef struct {
    int      pred;
    shortint pred_scaled;
  } pred_beat_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         command_i = CMD_NONE;
  logic [10:0]        weight_address_i = '0;
  logic signed [15:0] weight_value_i = '0;
  logic [3:0]         feature_index_i = '0;
  logic signed [31:0] sample_value_i = '0;
  logic               cfg_we_i = 1'b0;
  logic [0:0]         cfg_index_i = '0;
  logic [31:0]        cfg_data_i = '0;
  logic               result_valid_o;
  logic signed [31:0] prediction_o;
  logic signed [15:0] prediction_scaled_o;

  gru_cell_dense_head_inference dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20ns * 4_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  // mirror of the block state
  shortint     wmem [2048];
  shortint     hidden [HID];
  shortint     feat [IN_DIM];
  logic [31:0] in_recip;
  logic [31:0] out_range;

  pred_beat_t expected_preds[$];
  int         errors;
  int         items_sent;
  bit         no_idle;

  function automatic longint rsh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint wt(int a);
    return longint'(wmem[a & 2047]);
  endfunction

  // rational tanh, input with f fractional bits, result q4.12
  function automatic longint tanh_q12(longint v, int f);
    longint lim, x2, c, num, den;
    longint unsigned mag, q;
    lim = 64'sd3 <<< f;
    if (v > lim) return 4076;
    if (v < -lim) return -4076;
    x2  = v * v;
    c   = 64'sd27 <<< (2 * f);
    num = v * (c + x2);
    den = (c + 9 * x2) <<< (f - 12);
    mag = num < 0 ? longint'(-num) : num;
    q   = (mag + longint'(den) / 2) / longint'(den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sigm_q12(longint x);
    if (x > 32768) return 4095;
    if (x < -32768) return 1;
    return (tanh_q12(x, 13) + Q12_ONE + 1) >>> 1;
  endfunction

  function automatic shortint scale_sample(int s);
    longint v;
    if (in_recip == 0) v = rsh(longint'(s), 4);
    else v = rsh(longint'(s) * longint'(in_recip), 20);
    return shortint'(clamp(v, -32768, 32767));
  endfunction

  function automatic pred_beat_t gru_step();
    longint prev[HID];
    longint dense[DWID];
    longint zi, ri, ci, zr, rr, cr, z, r, cand, h, acc, pre, ps, pr, x;
    int base;
    pred_beat_t res;
    for (int u = 0; u < HID; u++) prev[u] = hidden[u];
    for (int u = 0; u < HID; u++) begin
      zi = wt(A_IBIAS + u) * Q12_ONE;
      ri = wt(A_IBIAS + HID + u) * Q12_ONE;
      ci = wt(A_IBIAS + 2 * HID + u) * Q12_ONE;
      zr = wt(A_RBIAS + u) * Q12_ONE;
      rr = wt(A_RBIAS + HID + u) * Q12_ONE;
      cr = wt(A_RBIAS + 2 * HID + u) * Q12_ONE;
      for (int i = 0; i < IN_DIM; i++) begin
        x = feat[i];
        base = i * GATES + u;
        zi += x * wt(base);
        ri += x * wt(base + HID);
        ci += x * wt(base + 2 * HID);
      end
      for (int i = 0; i < HID; i++) begin
        x = prev[i];
        base = A_RKER + i * GATES + u;
        zr += x * wt(base);
        rr += x * wt(base + HID);
        cr += x * wt(base + 2 * HID);
      end
      z = sigm_q12(rsh(zi + zr, 12));
      r = sigm_q12(rsh(ri + rr, 12));
      cand = tanh_q12(rsh(ci + rsh(r * cr, 12), 12), 12);
      h = rsh(z * prev[u] + (Q12_ONE - z) * cand, 12);
      hidden[u] = shortint'(clamp(h, -32768, 32767));
    end
    for (int o = 0; o < DWID; o++) begin
      acc = wt(A_DBIAS + o) * Q12_ONE;
      for (int i = 0; i < HID; i++) acc += longint'(hidden[i]) * wt(A_DKER + i * DWID + o);
      pre = rsh(acc, 12);
      dense[o] = clamp(rsh(pre * sigm_q12(pre), 12), -32768, 32767);
    end
    acc = wt(A_OBIAS) * Q12_ONE;
    for (int i = 0; i < DWID; i++) acc += dense[i] * wt(A_OKER + i);
    ps = clamp(rsh(acc, 12), -32768, 32767);
    pr = clamp(rsh(ps * longint'(out_range), 12), -64'sd2147483648, 64'sd2147483647);
    res.pred = int'(pr);
    res.pred_scaled = shortint'(ps);
    return res;
  endfunction

  // one command beat; returns at the edge that takes it, start left high
  task automatic send(logic [1:0] cmd, int addr, int wval, int idx, int sval);
    int key;
    if (!no_idle && $urandom_range(0, 99) < 9) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    start_i          <= 1'b1;
    command_i        <= cmd;
    weight_address_i <= addr[10:0];
    weight_value_i   <= wval[15:0];
    feature_index_i  <= idx[3:0];
    sample_value_i   <= sval;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    case (cmd)
      CMD_WRITE: wmem[addr & 2047] = shortint'(wval);
      CMD_CLEAR: foreach (hidden[k]) hidden[k] = 0;
      CMD_SAMPLE: begin
        key = idx & 15;
        if (key < IN_DIM) begin
          feat[key] = scale_sample(sval);
          if (key == IN_DIM - 1) expected_preds.push_back(gru_step());
        end
      end
      default: ;
    endcase
    if (cmd != CMD_NONE && !(cmd == CMD_SAMPLE && (idx & 15) >= IN_DIM)) items_sent++;
  endtask

  // wait until the block is quiet; write_reg then writes one register
  task automatic settle();
    start_i <= 1'b0;
    while (expected_preds.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [0:0] index, logic [31:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (index == REG_IN_RECIP) in_recip = value;
    else out_range = value;
  endtask

  task automatic load_weights(int mag);
    for (int a = 0; a < N_WORDS; a++)
      send(CMD_WRITE, a, $urandom_range(0, 2 * mag) - mag, 0, 0);
  endtask

  task automatic send_vector(int span);
    for (int i = 0; i < IN_DIM; i++)
      send(CMD_SAMPLE, 0, 0, i,
           span == 0 ? int'($urandom) : int'($urandom_range(0, 2 * span)) - span);
  endtask

  task automatic test_extremes();
    no_idle = 1'b1;
    load_weights(1500);
    no_idle = 1'b0;
    // sample extremes and a random-field sweep
    send(CMD_SAMPLE, 0, 0, 0, 32'h7fffffff);
    send(CMD_SAMPLE, 0, 0, 1, 32'h80000000);
    send(CMD_SAMPLE, 0, 0, 2, 0);
    send(CMD_SAMPLE, 0, 0, 3, 32'hffffffff);
    send_vector(1 << 18);
    // ignored beats
    send(CMD_NONE, 2047, 32'hffff, 15, 32'hffffffff);
    send(CMD_SAMPLE, 2047, 32'h8000, 15, 12345);
    send(CMD_SAMPLE, 0, 0, IN_DIM, -12345);
    // incomplete vector: only the last slot is refreshed
    send(CMD_SAMPLE, 0, 0, 3, 1 << 17);
    send(CMD_CLEAR, 0, 0, 0, 0);
    send(CMD_SAMPLE, 0, 0, 3, -(1 << 17));
    // top of the store, beyond the layout
    send(CMD_WRITE, 2047, 32'h7fff, 0, 0);
    send(CMD_WRITE, 1400, 32'h8000, 0, 0);
    // weight extremes in the output neuron
    send(CMD_WRITE, A_OBIAS, 32'h7fff, 0, 0);
    send(CMD_WRITE, A_OKER, 32'h8000, 0, 0);
    send_vector(1 << 18);
    send(CMD_WRITE, A_OBIAS, 0, 0, 0);
    send(CMD_WRITE, A_OKER, 100, 0, 0);
  endtask

  task automatic test_saturating_weights();
    load_weights(32767);
    send_vector(0);
    send_vector(1 << 18);
    load_weights(1500);
  endtask

  task automatic test_registers();
    logic [31:0] vals[4] = '{32'd0, 32'hffffffff, 32'd1, 32'd65536};
    foreach (vals[k]) begin
      write_reg(REG_IN_RECIP, vals[k]);
      write_reg(REG_OUT_RANGE, vals[3 - k]);
      send_vector(k == 1 ? 4096 : 1 << 18);
    end
    // scaling uses the register value at arrival
    send(CMD_SAMPLE, 0, 0, 0, 1 << 16);
    write_reg(REG_IN_RECIP, 32'd20000);
    send(CMD_SAMPLE, 0, 0, 1, 1 << 16);
    send(CMD_SAMPLE, 0, 0, 2, -(1 << 16));
    send(CMD_SAMPLE, 0, 0, 3, 1 << 15);
    write_reg(REG_IN_RECIP, 32'd65536);
    write_reg(REG_OUT_RANGE, 32'd65536);
  endtask

  task automatic test_random();
    int pick, next_cfg;
    items_sent = 0;
    next_cfg = 100;
    while (items_sent < 420) begin
      no_idle = items_sent > 150 && items_sent < 230;
      pick = $urandom_range(0, 99);
      if (pick < 65) send_vector($urandom_range(0, 3) == 0 ? 0 : 1 << 18);
      else if (pick < 78)
        send(CMD_WRITE, $urandom_range(0, 2047), $urandom_range(0, 3000) - 1500, 0, 0);
      else if (pick < 83) send(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 88) send(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
      else if (pick < 93) send(CMD_SAMPLE, $urandom, $urandom, $urandom_range(IN_DIM, 15), $urandom);
      else send(CMD_SAMPLE, $urandom, $urandom, $urandom_range(0, IN_DIM - 1), $urandom);
      if (items_sent >= next_cfg) begin
        next_cfg += 100;
        write_reg(REG_IN_RECIP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(30000, 90000));
        write_reg(REG_OUT_RANGE, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 18));
      end
    end
    no_idle = 1'b0;
  endtask

  // result checker: the block cannot be stalled, so every strobe is a beat
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_preds.size() == 0) begin
        $display("%0t: unexpected beat pred=%0d scaled=%0d", $time, prediction_o,
                 prediction_scaled_o);
        errors++;
      end else begin
        pred_beat_t e;
        e = expected_preds.pop_front();
        if (prediction_o !== e.pred) begin
          $display("%0t: prediction expected %0d actual %0d", $time, e.pred, prediction_o);
          errors++;
        end
        if (prediction_scaled_o !== e.pred_scaled) begin
          $display("%0t: prediction_scaled expected %0d actual %0d", $time, e.pred_scaled,
                   prediction_scaled_o);
          errors++;
        end
      end
    end
  end

  initial begin
    errors    = 0;
    no_idle   = 1'b0;
    in_recip  = 32'd65536;
    out_range = 32'd65536;
    foreach (hidden[k]) hidden[k] = 0;
    foreach (feat[k]) feat[k] = 0;
    foreach (wmem[k]) wmem[k] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_saturating_weights();
    test_registers();
    test_random();
    settle();
    repeat (100) @(posedge clk_i);
    if (errors == 0 && expected_preds.size() == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
